// ----- sv/lnk_pkg.sv -----
// Shared types and constants for the link detect / handshake block.
// Used by every module in this folder; no dependencies.
package lnk_pkg;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOCAL = 2'd1;
    localparam logic [1:0] ST_CONN  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_HELLO   = 3'd1;
    localparam logic [2:0] K_REPLY   = 3'd2;
    localparam logic [2:0] K_GOODBYE = 3'd3;
    localparam logic [2:0] K_BEAT    = 3'd4;

    localparam logic [7:0] RXK_HELLO = 8'h01;
    localparam logic [7:0] RXK_REPLY = 8'h02;
    localparam logic [7:0] RXK_BYE   = 8'h03;
    localparam logic [7:0] RXK_BEAT  = 8'h04;

    localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HELLO_TMO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HELLO_RETRY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEAT_TMO     = 3'd4;

    localparam logic [15:0] HELLO_TMO_RST   = 16'd1000;
    localparam logic [3:0]  HELLO_RETRY_RST = 4'd3;
    localparam logic [15:0] BEAT_PERIOD_RST = 16'd1000;
    localparam logic [15:0] BEAT_TMO_RST    = 16'd3000;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic        detect_is_low;
        logic        msg_valid;
        logic [7:0]  msg_kind;
        logic [15:0] msg_sender;
        logic [47:0] msg_source_addr;
        logic [31:0] now_ms;
    } tick_t;

    // one accepted tick: up to two sends plus the state after the tick
    typedef struct packed {
        logic [1:0]  cnt;
        logic [2:0]  kind0;
        logic [47:0] dest0;
        logic [2:0]  kind1;
        logic [47:0] dest1;
        logic [1:0]  status;
        logic [15:0] neigh;
    } rec_t;

endpackage

// ----- sv/link_detect_handshake_fsm.sv -----
// Link detect / handshake controller, top level.
// The first result of a tick passes through the record queue, then the output register.
// Throughput: one tick per cycle while in_stall is low; results leave at one per cycle
// while out_stall is low, so a two-result tick is split into two output items (4-record queue).
// Reset (rst_n low, async): link idle, timers zero, config at defaults.
// Depends on lnk_pkg, lnk_front, lnk_queue, lnk_back.
module link_detect_handshake_fsm (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           detect_is_low,
    input  logic                           msg_valid,
    input  logic [7:0]                     msg_kind,
    input  logic [15:0]                    msg_sender,
    input  logic [47:0]                    msg_source_addr,
    input  logic [31:0]                    now_ms,
    input  logic                           cfg_we,
    input  logic [lnk_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lnk_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           send_valid,
    output logic [2:0]                     send_kind,
    output logic [47:0]                    dest_addr,
    output logic [1:0]                     link_status,
    output logic [15:0]                    neighbour,
    output logic                           last_of_tick
);
    import lnk_pkg::*;

    tick_t tick;
    rec_t  rec, head;
    logic  take, pop, empty, full;

    assign tick.detect_is_low   = detect_is_low;
    assign tick.msg_valid       = msg_valid;
    assign tick.msg_kind        = msg_kind;
    assign tick.msg_sender      = msg_sender;
    assign tick.msg_source_addr = msg_source_addr;
    assign tick.now_ms          = now_ms;

    assign in_stall = full;
    assign take     = in_valid && !full;

    lnk_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_take (take),
        .tick      (tick),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec       (rec)
    );

    lnk_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take),
        .push_rec (rec),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    lnk_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .send_valid   (send_valid),
        .send_kind    (send_kind),
        .dest_addr    (dest_addr),
        .link_status  (link_status),
        .neighbour    (neighbour),
        .last_of_tick (last_of_tick)
    );

endmodule

// ----- sv/lnk_front.sv -----
// Front end: accepts ticks, holds link state and configuration, builds records.
// Depends on lnk_pkg.
module lnk_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_take,
    input  lnk_pkg::tick_t                tick,
    input  logic                          cfg_we,
    input  logic [lnk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lnk_pkg::CFG_DATA_W-1:0] cfg_data,
    output lnk_pkg::rec_t                 rec
);
    import lnk_pkg::*;

    logic [15:0] own_id_reg;
    logic [15:0] hello_tmo_reg;
    logic [3:0]  hello_retry_reg;
    logic [15:0] beat_period_reg;
    logic [15:0] beat_tmo_reg;

    logic [1:0]  state_reg, state_next;
    logic        prev_det_reg;
    logic [15:0] neigh_id_reg, neigh_id_next;
    logic [47:0] neigh_addr_reg, neigh_addr_next;
    logic        peer_known_reg, peer_known_next;
    logic [3:0]  retry_reg, retry_next;
    logic [31:0] hello_time_reg, hello_time_next;
    logic [31:0] beat_sent_reg, beat_sent_next;
    logic [31:0] beat_heard_reg, beat_heard_next;

    logic        fell, rose, is_hello, is_reply, is_bye, is_beat;
    logic        from_self, from_neigh;
    logic        hello_late, beat_due, beat_lost;
    logic [1:0]  n;
    logic [2:0]  k0, k1;
    logic [47:0] d0, d1;

    always_comb
    begin
        fell       = tick.detect_is_low & ~prev_det_reg;
        rose       = ~tick.detect_is_low & prev_det_reg;
        is_hello   = tick.msg_valid && tick.msg_kind == RXK_HELLO;
        is_reply   = tick.msg_valid && tick.msg_kind == RXK_REPLY;
        is_bye     = tick.msg_valid && tick.msg_kind == RXK_BYE;
        is_beat    = tick.msg_valid && tick.msg_kind == RXK_BEAT;
        from_self  = tick.msg_sender == own_id_reg;
        from_neigh = tick.msg_sender == neigh_id_reg;
        hello_late = (tick.now_ms - hello_time_reg) > {16'd0, hello_tmo_reg};
        beat_due   = (tick.now_ms - beat_sent_reg) > {16'd0, beat_period_reg};
        beat_lost  = (tick.now_ms - beat_heard_reg) > {16'd0, beat_tmo_reg};

        state_next      = state_reg;
        neigh_id_next   = neigh_id_reg;
        neigh_addr_next = neigh_addr_reg;
        peer_known_next = peer_known_reg;
        retry_next      = retry_reg;
        hello_time_next = hello_time_reg;
        beat_sent_next  = beat_sent_reg;
        beat_heard_next = beat_heard_reg;
        n  = 2'd0;
        k0 = K_NONE;
        k1 = K_NONE;
        d0 = '0;
        d1 = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fell)
                begin
                    retry_next      = 4'd0;
                    hello_time_next = tick.now_ms;
                    k0              = K_HELLO;
                    d0              = BCAST_ADDR;
                    n               = 2'd1;
                    state_next      = ST_LOCAL;
                end
                if (is_hello)
                begin
                    if (n == 2'd0)
                    begin
                        k0 = K_REPLY;
                        d0 = tick.msg_source_addr;
                    end
                    else
                    begin
                        k1 = K_REPLY;
                        d1 = tick.msg_source_addr;
                    end
                    n               = n + 2'd1;
                    neigh_addr_next = tick.msg_source_addr;
                    peer_known_next = 1'b1;
                    neigh_id_next   = tick.msg_sender;
                    beat_heard_next = tick.now_ms;
                    beat_sent_next  = tick.now_ms;
                    state_next      = ST_CONN;
                end
            end
            ST_LOCAL:
            begin
                priority if ((is_reply || is_hello) && !from_self)
                begin
                    if (is_hello)
                    begin
                        k0 = K_REPLY;
                        d0 = tick.msg_source_addr;
                        n  = 2'd1;
                    end
                    neigh_addr_next = tick.msg_source_addr;
                    peer_known_next = 1'b1;
                    neigh_id_next   = tick.msg_sender;
                    beat_heard_next = tick.now_ms;
                    beat_sent_next  = tick.now_ms;
                    state_next      = ST_CONN;
                end
                else if (rose)
                begin
                    neigh_id_next = 16'd0;
                    retry_next    = 4'd0;
                    state_next    = ST_IDLE;
                end
                else if (hello_late)
                begin
                    retry_next = retry_reg + 4'd1;
                    if (retry_next >= hello_retry_reg)
                    begin
                        state_next = ST_ERROR;
                    end
                    else
                    begin
                        hello_time_next = tick.now_ms;
                        k0              = K_HELLO;
                        d0              = BCAST_ADDR;
                        n               = 2'd1;
                    end
                end
            end
            ST_CONN:
            begin
                priority if (rose)
                begin
                    if (peer_known_reg)
                    begin
                        k0 = K_GOODBYE;
                        d0 = neigh_addr_reg;
                        n  = 2'd1;
                    end
                    neigh_id_next = 16'd0;
                    retry_next    = 4'd0;
                    state_next    = ST_IDLE;
                end
                else if (is_bye && from_neigh)
                begin
                    neigh_id_next = 16'd0;
                    retry_next    = 4'd0;
                    state_next    = ST_IDLE;
                end
                else if (is_beat && from_neigh)
                begin
                    beat_heard_next = tick.now_ms;
                end
                else if (is_hello && from_neigh)
                begin
                    k0 = K_REPLY;
                    d0 = tick.msg_source_addr;
                    n  = 2'd1;
                end
                if (state_next == ST_CONN && beat_due)
                begin
                    if (peer_known_reg)
                    begin
                        if (n == 2'd0)
                        begin
                            k0 = K_BEAT;
                            d0 = neigh_addr_reg;
                        end
                        else
                        begin
                            k1 = K_BEAT;
                            d1 = neigh_addr_reg;
                        end
                        n = n + 2'd1;
                    end
                    beat_sent_next = tick.now_ms;
                end
                // heard time only moves forward to now, so the old value decides
                if (state_next == ST_CONN && (beat_lost && beat_heard_next == beat_heard_reg))
                begin
                    neigh_id_next = 16'd0;
                    retry_next    = 4'd0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                if (fell || rose)
                begin
                    neigh_id_next = 16'd0;
                    retry_next    = 4'd0;
                    state_next    = ST_IDLE;
                end
            end
        endcase

        rec.cnt    = n;
        rec.kind0  = k0;
        rec.dest0  = d0;
        rec.kind1  = k1;
        rec.dest1  = d1;
        rec.status = state_next;
        rec.neigh  = neigh_id_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg      <= 16'd0;
            hello_tmo_reg   <= HELLO_TMO_RST;
            hello_retry_reg <= HELLO_RETRY_RST;
            beat_period_reg <= BEAT_PERIOD_RST;
            beat_tmo_reg    <= BEAT_TMO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_ID:      own_id_reg      <= cfg_data;
                REG_HELLO_TMO:   hello_tmo_reg   <= cfg_data;
                REG_HELLO_RETRY: hello_retry_reg <= cfg_data[3:0];
                REG_BEAT_PERIOD: beat_period_reg <= cfg_data;
                REG_BEAT_TMO:    beat_tmo_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_det_reg   <= 1'b0;
            neigh_id_reg   <= 16'd0;
            neigh_addr_reg <= 48'd0;
            peer_known_reg <= 1'b0;
            retry_reg      <= 4'd0;
            hello_time_reg <= 32'd0;
            beat_sent_reg  <= 32'd0;
            beat_heard_reg <= 32'd0;
        end
        else if (tick_take)
        begin
            state_reg      <= state_next;
            prev_det_reg   <= tick.detect_is_low;
            neigh_id_reg   <= neigh_id_next;
            neigh_addr_reg <= neigh_addr_next;
            peer_known_reg <= peer_known_next;
            retry_reg      <= retry_next;
            hello_time_reg <= hello_time_next;
            beat_sent_reg  <= beat_sent_next;
            beat_heard_reg <= beat_heard_next;
        end
    end

endmodule

// ----- sv/lnk_queue.sv -----
// Short record queue between front and back end.
// Depends on lnk_pkg.
module lnk_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lnk_pkg::rec_t push_rec,
    input  logic          pop,
    output lnk_pkg::rec_t head,
    output logic          empty,
    output logic          full
);
    import lnk_pkg::*;

    rec_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg, count_next;

    assign empty = count_reg == '0;
    assign full  = count_reg == (QAW + 1)'(QDEPTH);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/lnk_back.sv -----
// Back end: splits each record into one or two result items, output register.
// Depends on lnk_pkg.
module lnk_back (
    input  logic          clk,
    input  logic          rst_n,
    input  lnk_pkg::rec_t head,
    input  logic          empty,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          send_valid,
    output logic [2:0]    send_kind,
    output logic [47:0]   dest_addr,
    output logic [1:0]    link_status,
    output logic [15:0]   neighbour,
    output logic          last_of_tick
);
    import lnk_pkg::*;

    logic        valid_reg, valid_next;
    logic        half_reg, half_next;
    logic        send_reg;
    logic [2:0]  kind_reg;
    logic [47:0] dest_reg;
    logic [1:0]  status_reg;
    logic [15:0] neigh_reg;
    logic        last_reg;
    logic        load, two, first_of_two;

    always_comb
    begin
        load         = !valid_reg || !out_stall;
        two          = head.cnt == 2'd2;
        first_of_two = two && !half_reg;
        pop          = load && !empty && !first_of_two;
        valid_next   = load ? !empty : valid_reg;
        half_next    = (load && !empty) ? first_of_two : half_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            send_reg   <= head.cnt != 2'd0;
            kind_reg   <= half_reg ? head.kind1 : head.kind0;
            dest_reg   <= half_reg ? head.dest1 : head.dest0;
            status_reg <= head.status;
            neigh_reg  <= head.neigh;
            last_reg   <= !first_of_two;
        end
    end

    assign out_valid    = valid_reg;
    assign send_valid   = send_reg;
    assign send_kind    = kind_reg;
    assign dest_addr    = dest_reg;
    assign link_status  = status_reg;
    assign neighbour    = neigh_reg;
    assign last_of_tick = last_reg;

endmodule

// ----- sv/lnk_checker.sv -----
// Port-level checks for link_detect_handshake_fsm, with bind.
// Depends on lnk_pkg.
module lnk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        send_valid,
    input logic [2:0]  send_kind,
    input logic [47:0] dest_addr,
    input logic [1:0]  link_status,
    input logic [15:0] neighbour,
    input logic        last_of_tick
);
    import lnk_pkg::*;

    a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_valid |-> last_of_tick && send_kind == K_NONE && dest_addr == '0)
        else $error("no-send result must be lone and zero");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_valid |-> send_kind == K_HELLO || send_kind == K_REPLY ||
                                    send_kind == K_GOODBYE || send_kind == K_BEAT)
        else $error("bad send kind");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_tick |=> out_valid && send_valid)
        else $error("second result of tick missing");

    a_no_neigh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (link_status == ST_IDLE || link_status == ST_LOCAL ||
                      link_status == ST_ERROR) |-> neighbour == 16'd0)
        else $error("neighbour set while not connected");

endmodule

bind link_detect_handshake_fsm lnk_checker u_lnk_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .send_valid   (send_valid),
    .send_kind    (send_kind),
    .dest_addr    (dest_addr),
    .link_status  (link_status),
    .neighbour    (neighbour),
    .last_of_tick (last_of_tick)
);
